// ===== design/bounded_lifo_stack_with_search_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded LIFO stack with search.
// Each macro checks one property on the rising edge of clk outside reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIFO_STACK_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_LIFO_STACK_WITH_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/blss_pkg.sv =====
// ----------------------------------------------------------------------------
// blss_pkg
// Shared types and constants of the bounded LIFO stack with search.
// ----------------------------------------------------------------------------
`default_nettype none

package blss_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned CAP_W    = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_FLUSH  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OUT_SCOPE = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH
  } state_t;

endpackage

`default_nettype wire

// ===== design/blss_ram.sv =====
// ----------------------------------------------------------------------------
// blss_ram
// Entry store of the stack: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module blss_ram #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_WIDTH-1:0]    wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/bounded_lifo_stack_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_lifo_stack_with_search
// Bounded LIFO stack with push, pop, positional peek, bottom-up search and
// flush, kept in one synchronous memory.
//
// An item is taken at a clock edge where start is high and busy is low. Its
// one result appears for a single cycle with out_valid high; the receiver
// cannot stall it. Push, flush, unused codes, a pop that empties the stack
// and every refused request give their result in the cycle after the item.
// A pop that leaves entries behind and a valid peek pass through the read
// state, since the new top or the peeked entry comes from the memory read
// port. A search reads one entry per cycle from the bottom and ends at the
// first match or at the top entry. busy is high while a memory read is
// outstanding.
// The user writes the capacity register with cfg_wr_en only while idle; the
// block itself does not enforce this. Reset empties the stack and sets the
// capacity to 100; the memory is left uncleared, as only live entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_lifo_stack_with_search #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [blss_pkg::CAP_W-1:0]      cfg_wr_data,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [blss_pkg::OP_W-1:0]       in_operation,
  input  wire logic [DATA_WIDTH-1:0]           in_data_value,
  input  wire logic [blss_pkg::CNT_W-1:0]      in_position,
  output logic                                 out_valid,
  output logic      [DATA_WIDTH-1:0]           out_read_value,
  output logic      [blss_pkg::CNT_W-1:0]      out_found_position,
  output logic      [blss_pkg::STATUS_W-1:0]   out_status,
  output logic      [blss_pkg::CNT_W-1:0]      out_entry_count,
  output logic                                 out_is_full,
  output logic                                 out_is_empty,
  output logic      [DATA_WIDTH-1:0]           out_top_value,
  output logic      [DATA_WIDTH-1:0]           out_bottom_value
);

  import blss_pkg::*;

  `include "bounded_lifo_stack_with_search_assert.svh"

  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CNT_LIMIT = (1 << CNT_W) - 1;
  localparam int unsigned DEPTH_CAP = (DEPTH > CNT_LIMIT) ? CNT_LIMIT : DEPTH;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH_CAP);

  state_t                state_r, state_nxt;
  logic [CAP_W-1:0]      cap_r;
  logic [CNT_W-1:0]      count_r;
  logic [DATA_WIDTH-1:0] top_r;
  logic [DATA_WIDTH-1:0] bottom_r;
  op_t                   op_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [AW-1:0]         idx_r;
  logic                  valid_r;
  logic [DATA_WIDTH-1:0] rd_val_r;
  logic [CNT_W-1:0]      found_r;
  status_t               status_r;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                  accept;
  op_t                   in_op;
  logic [CNT_W-1:0]      eff_cap;
  logic                  has_room;
  logic                  peek_ok;
  logic                  srch_hit;
  logic                  srch_last;

  assign in_op     = op_t'(in_operation);
  assign accept    = start && (state_r == S_IDLE);
  assign eff_cap   = (cap_r > CNT_MAX) ? CNT_MAX : cap_r;
  assign has_room  = count_r < eff_cap;
  assign peek_ok   = (in_position != '0) && (in_position <= count_r);
  assign srch_hit  = mem_rdata == data_r;
  assign srch_last = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  blss_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_POP && count_r > CNT_W'(1)) begin
            state_nxt = S_READ;
          end else if (in_op == OP_PEEK && peek_ok) begin
            state_nxt = S_READ;
          end else if (in_op == OP_SEARCH && count_r != '0) begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        if (srch_hit || srch_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy      = state_r != S_IDLE;
    mem_we    = 1'b0;
    mem_waddr = AW'(count_r);
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_PUSH: begin
              mem_we = has_room;
            end
            OP_POP: begin
              mem_re    = count_r > CNT_W'(1);
              mem_raddr = AW'(count_r - CNT_W'(2));
            end
            OP_PEEK: begin
              mem_re    = peek_ok;
              mem_raddr = AW'(in_position - CNT_W'(1));
            end
            OP_SEARCH: begin
              mem_re = count_r != '0;
            end
            default: begin
              mem_re = 1'b0;
            end
          endcase
        end
      end
      S_SEARCH: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r + AW'(1);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cap_r    <= CAP_RESET;
      count_r  <= '0;
      top_r    <= '0;
      bottom_r <= '0;
      valid_r  <= 1'b0;
      op_r     <= OP_PUSH;
      data_r   <= '0;
      idx_r    <= '0;
      rd_val_r <= '0;
      found_r  <= '0;
      status_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      valid_r <= 1'b0;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r     <= in_op;
            data_r   <= in_data_value;
            idx_r    <= '0;
            rd_val_r <= '0;
            found_r  <= '0;
            status_r <= ST_OK;
            valid_r  <= 1'b1;
            unique case (in_op)
              OP_PUSH: begin
                if (has_room) begin
                  count_r <= count_r + CNT_W'(1);
                  top_r   <= in_data_value;
                  if (count_r == '0) begin
                    bottom_r <= in_data_value;
                  end
                end else begin
                  status_r <= ST_OVERFLOW;
                end
              end
              OP_POP: begin
                if (count_r == '0) begin
                  rd_val_r <= DATA_WIDTH'(1);
                  status_r <= ST_UNDERFLOW;
                end else begin
                  count_r <= count_r - CNT_W'(1);
                  if (count_r == CNT_W'(1)) begin
                    rd_val_r <= top_r;
                    top_r    <= '0;
                    bottom_r <= '0;
                  end else begin
                    valid_r <= 1'b0;
                  end
                end
              end
              OP_PEEK: begin
                if (peek_ok) begin
                  valid_r <= 1'b0;
                end else begin
                  status_r <= ST_OUT_SCOPE;
                end
              end
              OP_SEARCH: begin
                if (count_r == '0) begin
                  status_r <= ST_NOT_FOUND;
                end else begin
                  valid_r <= 1'b0;
                end
              end
              OP_FLUSH: begin
                count_r  <= '0;
                top_r    <= '0;
                bottom_r <= '0;
              end
              default: begin
                status_r <= ST_OK;
              end
            endcase
          end
        end
        S_READ: begin
          valid_r <= 1'b1;
          if (op_r == OP_POP) begin
            rd_val_r <= top_r;
            top_r    <= mem_rdata;
          end else begin
            rd_val_r <= mem_rdata;
          end
        end
        S_SEARCH: begin
          idx_r <= idx_r + AW'(1);
          if (srch_hit) begin
            valid_r <= 1'b1;
            found_r <= CNT_W'(idx_r) + CNT_W'(1);
          end else if (srch_last) begin
            valid_r  <= 1'b1;
            status_r <= ST_NOT_FOUND;
          end
        end
        default: begin
          valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid          = valid_r;
  assign out_read_value     = rd_val_r;
  assign out_found_position = found_r;
  assign out_status         = status_r;
  assign out_entry_count    = count_r;
  assign out_is_full        = count_r >= eff_cap;
  assign out_is_empty       = count_r == '0;
  assign out_top_value      = top_r;
  assign out_bottom_value   = bottom_r;

  `BLSS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_MAX, "count exceeds stack depth")
  `BLSS_ASSERT_SAME(a_search_idx, state_r == S_SEARCH, CNT_W'(idx_r) < count_r, "search past top")
  `BLSS_ASSERT_SAME(a_done_strobe, $fell(busy), out_valid, "read finished without a result")
  `BLSS_ASSERT_NEXT(a_read_once, state_r == S_READ, state_r == S_IDLE, "read state held")
  `BLSS_ASSERT_SAME(a_empty_zero, out_is_empty, top_r == '0 && bottom_r == '0, "empty stack shows data")

endmodule

`default_nettype wire

// ===== tb/tb_bounded_lifo_stack_with_search.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_lifo_stack_with_search
// Self-checking testbench for the bounded LIFO stack with search. A short
// table of directed items covers the empty and full stack, the extreme data
// values, every operation and the unused codes, with hand-written results
// where they are obvious. Random phases follow, each under its own capacity,
// and fill, drain and refill the stack, mostly with the sender idling in bursts.
// Every accepted item is run through a behavioral copy of the stack, and each
// result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------

module tb_bounded_lifo_stack_with_search;
  import blss_pkg::*;

  localparam int unsigned STACK_DEPTH  = 128;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 2 * STACK_DEPTH;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned NUM_PHASES   = 10;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

  typedef struct {
    logic [WORD_W-1:0] read_value;
    logic [CNT_W-1:0]  found_pos;
    status_t           status;
    logic [CNT_W-1:0]  count;
    logic              full;
    logic              empty;
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] bottom;
  } stack_result_t;

  typedef struct {
    bit                is_cfg;
    logic [CAP_W-1:0]  cap;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] data;
    logic [CNT_W-1:0]  pos;
    bit                typed;
    stack_result_t     want;
  } directed_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CAP_W-1:0]  cfg_wr_data;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   in_operation;
  logic [WORD_W-1:0] in_data_value;
  logic [CNT_W-1:0]  in_position;
  logic              out_valid;
  logic [WORD_W-1:0] out_read_value;
  logic [CNT_W-1:0]  out_found_position;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_is_full;
  logic              out_is_empty;
  logic [WORD_W-1:0] out_top_value;
  logic [WORD_W-1:0] out_bottom_value;

  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       stack_count;
  logic [CAP_W-1:0]  capacity_reg;

  stack_result_t     pending_results[$];
  directed_row_t     directed_rows[$];
  bit                item_typed_flag;
  stack_result_t     item_typed_result;
  int unsigned       error_count;
  int unsigned       cycle_count;

  int unsigned phase_cap[NUM_PHASES]   = '{1, 0, 255, 5, 128, 128, 2, 100, 1, 0};
  int unsigned phase_push[NUM_PHASES]  = '{50, 50, 85, 40, 85, 30, 50, 60, 55, 65};
  int unsigned phase_items[NUM_PHASES] = '{120, 80, 260, 120, 250, 200, 120, 200, 200, 200};
  bit          phase_steady[NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0};

  bounded_lifo_stack_with_search #(
    .DEPTH      (STACK_DEPTH),
    .DATA_WIDTH (WORD_W)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_data_value      (in_data_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_is_full        (out_is_full),
    .out_is_empty       (out_is_empty),
    .out_top_value      (out_top_value),
    .out_bottom_value   (out_bottom_value)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic stack_result_t result_of(logic [WORD_W-1:0] rd, logic [CNT_W-1:0] found,
                                              status_t st, logic [CNT_W-1:0] cnt,
                                              logic full, logic empty,
                                              logic [WORD_W-1:0] top,
                                              logic [WORD_W-1:0] bottom);
    stack_result_t r;
    r.read_value = rd;
    r.found_pos  = found;
    r.status     = st;
    r.count      = cnt;
    r.full       = full;
    r.empty      = empty;
    r.top        = top;
    r.bottom     = bottom;
    return r;
  endfunction

  function automatic string fmt_result(stack_result_t r);
    return $sformatf("rd=%h found=%0d status=%0d count=%0d full=%b empty=%b top=%h bottom=%h",
                     r.read_value, r.found_pos, r.status, r.count, r.full, r.empty,
                     r.top, r.bottom);
  endfunction

  // Behavioral stack: applies one item to the local copy and returns its result.
  task automatic apply_stack_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] data,
                                input logic [CNT_W-1:0] pos, output stack_result_t r);
    int unsigned eff_cap;
    int unsigned k;
    r = result_of('0, '0, ST_OK, '0, 1'b0, 1'b0, '0, '0);
    eff_cap = (capacity_reg > STACK_DEPTH) ? STACK_DEPTH : capacity_reg;
    case (op)
      OP_PUSH: begin
        if (stack_count < eff_cap) begin
          stack_mem[stack_count] = data;
          stack_count++;
        end else begin
          r.status = ST_OVERFLOW;
        end
      end
      OP_POP: begin
        if (stack_count > 0) begin
          stack_count--;
          r.read_value = stack_mem[stack_count];
          stack_mem[stack_count] = '0;
        end else begin
          r.read_value = 1;
          r.status     = ST_UNDERFLOW;
        end
      end
      OP_PEEK: begin
        if (pos >= 1 && pos <= stack_count) begin
          r.read_value = stack_mem[pos-1];
        end else begin
          r.status = ST_OUT_SCOPE;
        end
      end
      OP_SEARCH: begin
        for (k = 0; k < stack_count && r.found_pos == 0; k++) begin
          if (stack_mem[k] == data) begin
            r.found_pos = CNT_W'(k + 1);
          end
        end
        if (r.found_pos == 0) begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_FLUSH: begin
        foreach (stack_mem[i]) stack_mem[i] = '0;
        stack_count = 0;
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(stack_count);
    r.full  = (stack_count >= eff_cap);
    r.empty = (stack_count == 0);
    if (stack_count > 0) begin
      r.top    = stack_mem[stack_count-1];
      r.bottom = stack_mem[0];
    end
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    stack_result_t want;
    stack_result_t seen;
    stack_result_t predicted;
    if (rst_n) begin
      if (cfg_wr_en) begin
        capacity_reg = cfg_wr_data;
      end
      if (out_valid) begin
        seen = result_of(out_read_value, out_found_position, status_t'(out_status),
                         out_entry_count, out_is_full, out_is_empty, out_top_value,
                         out_bottom_value);
        if (pending_results.size() == 0) begin
          note_error({"Unexpected result: ", fmt_result(seen)});
        end else begin
          want = pending_results.pop_front();
          if (seen.read_value !== want.read_value || seen.found_pos !== want.found_pos ||
              seen.status !== want.status || seen.count !== want.count ||
              seen.full !== want.full || seen.empty !== want.empty ||
              seen.top !== want.top || seen.bottom !== want.bottom) begin
            note_error({"Mismatch at cycle ", $sformatf("%0d", cycle_count),
                        "\n  expected ", fmt_result(want), "\n  actual   ", fmt_result(seen)});
          end
        end
      end
      if (start && !busy) begin
        apply_stack_op(in_operation, in_data_value, in_position, predicted);
        pending_results.push_back(item_typed_flag ? item_typed_result : predicted);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] data,
                           input logic [CNT_W-1:0] pos, input bit typed,
                           input stack_result_t want);
    @(negedge clk);
    start         <= 1'b1;
    in_operation  <= op;
    in_data_value <= data;
    in_position   <= pos;
    item_typed_flag   = typed;
    item_typed_result = want;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_capacity(input int unsigned value);
    idle_cycles(1);
    wait_results_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CAP_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic add_typed(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] data,
                           input logic [CNT_W-1:0] pos, input stack_result_t want);
    directed_row_t row;
    row.is_cfg = 1'b0;
    row.cap    = '0;
    row.op     = op;
    row.data   = data;
    row.pos    = pos;
    row.typed  = 1'b1;
    row.want   = want;
    directed_rows.push_back(row);
  endtask

  task automatic add_checked(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] data,
                             input logic [CNT_W-1:0] pos);
    add_typed(op, data, pos, result_of('0, '0, ST_OK, '0, 1'b0, 1'b0, '0, '0));
    directed_rows[directed_rows.size()-1].typed = 1'b0;
  endtask

  task automatic add_cfg(input logic [CAP_W-1:0] cap);
    add_checked(OP_PUSH, '0, '0);
    directed_rows[directed_rows.size()-1].is_cfg = 1'b1;
    directed_rows[directed_rows.size()-1].cap    = cap;
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return WORD_W'($urandom_range(0, 3));
      3:       return '1;
      4:       return '0;
      5:       return {1'b1, {(WORD_W-1){1'b0}}};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item(input int unsigned push_pct);
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] data;
    logic [CNT_W-1:0]  pos;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      op = OP_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4 && push_pct < 70) begin
        op = OP_FLUSH;
      end else if (r < 8) begin
        op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end else if (r < 40) begin
        op = OP_POP;
      end else if (r < 70) begin
        op = OP_PEEK;
      end else begin
        op = OP_SEARCH;
      end
    end
    data = random_word();
    if (op == OP_SEARCH && stack_count > 0 && $urandom_range(0, 99) < 60) begin
      data = stack_mem[$urandom_range(0, stack_count - 1)];
    end
    r = $urandom_range(0, 9);
    if (r < 6 && stack_count > 0) begin
      pos = CNT_W'($urandom_range(1, stack_count));
    end else if (r == 6) begin
      pos = '0;
    end else if (r == 7) begin
      pos = CNT_W'(stack_count + 1);
    end else begin
      pos = CNT_W'($urandom_range(0, 255));
    end
    send_item(op, data, pos, 1'b0, item_typed_result);
  endtask

  initial begin : stimulus
    int unsigned burst_left;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    start         = 1'b0;
    in_operation  = OP_PUSH;
    in_data_value = '0;
    in_position   = '0;
    item_typed_flag   = 1'b0;
    item_typed_result = result_of('0, '0, ST_OK, '0, 1'b0, 1'b0, '0, '0);
    error_count   = 0;
    cycle_count   = 0;
    stack_count   = 0;
    capacity_reg  = CAP_RESET;
    foreach (stack_mem[i]) stack_mem[i] = '0;

    add_typed(OP_POP,    '0, '0, result_of(1, 0, ST_UNDERFLOW, 0, 0, 1, 0, 0));
    add_typed(OP_PEEK,   '0, '0, result_of(0, 0, ST_OUT_SCOPE, 0, 0, 1, 0, 0));
    add_typed(OP_SEARCH, '0, '0, result_of(0, 0, ST_NOT_FOUND, 0, 0, 1, 0, 0));
    add_typed(OP_PUSH, 32'hFFFF_FFFF, '0,
              result_of(0, 0, ST_OK, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_typed(OP_PUSH, '0, 8'hFF, result_of(0, 0, ST_OK, 2, 0, 0, 0, 32'hFFFF_FFFF));
    add_typed(OP_PUSH, 32'h8000_0001, '0,
              result_of(0, 0, ST_OK, 3, 0, 0, 32'h8000_0001, 32'hFFFF_FFFF));
    add_typed(OP_PEEK, '0, 8'd1,
              result_of(32'hFFFF_FFFF, 0, ST_OK, 3, 0, 0, 32'h8000_0001, 32'hFFFF_FFFF));
    add_typed(OP_PEEK, '0, 8'd3,
              result_of(32'h8000_0001, 0, ST_OK, 3, 0, 0, 32'h8000_0001, 32'hFFFF_FFFF));
    add_typed(OP_PEEK, '0, 8'd4,
              result_of(0, 0, ST_OUT_SCOPE, 3, 0, 0, 32'h8000_0001, 32'hFFFF_FFFF));
    add_typed(OP_PEEK, '0, 8'hFF,
              result_of(0, 0, ST_OUT_SCOPE, 3, 0, 0, 32'h8000_0001, 32'hFFFF_FFFF));
    add_typed(OP_SEARCH, '0, '0,
              result_of(0, 2, ST_OK, 3, 0, 0, 32'h8000_0001, 32'hFFFF_FFFF));
    add_checked(OP_SEARCH, 32'h8000_0001, '0);
    add_checked(OP_SEARCH, 32'h1234_5678, 8'd2);
    add_checked(OP_FIRST_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    add_checked(OP_LAST_UNUSED, 32'h5555_AAAA, 8'd1);
    add_typed(OP_POP, '0, '0,
              result_of(32'h8000_0001, 0, ST_OK, 2, 0, 0, 0, 32'hFFFF_FFFF));
    add_typed(OP_FLUSH, '0, '0, result_of(0, 0, ST_OK, 0, 0, 1, 0, 0));
    add_cfg(8'd1);
    add_typed(OP_PUSH, 32'd7, '0, result_of(0, 0, ST_OK, 1, 1, 0, 7, 7));
    add_typed(OP_PUSH, 32'd9, '0, result_of(0, 0, ST_OVERFLOW, 1, 1, 0, 7, 7));
    add_cfg(8'd0);
    add_checked(OP_PEEK, '0, 8'd1);
    add_typed(OP_POP, '0, '0, result_of(7, 0, ST_OK, 0, 1, 1, 0, 0));
    add_typed(OP_PUSH, 32'd3, '0, result_of(0, 0, ST_OVERFLOW, 0, 1, 1, 0, 0));
    add_cfg(8'hFF);
    add_checked(OP_PUSH, 32'h5A5A_5A5A, '0);
    add_checked(OP_SEARCH, 32'h5A5A_5A5A, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_capacity(directed_rows[i].cap);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].pos,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    phase_cap[8] = $urandom_range(1, 16);
    phase_cap[9] = $urandom_range(0, 255);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_cap[p]);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < phase_items[p]; n++) begin
        send_random_item(phase_push[p]);
        if (!phase_steady[p]) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
          end
        end
      end
    end

    idle_cycles(1);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
